// ----- design/wdfs_pkg.sv -----
package wdfs_pkg;

    localparam int COEF_WIDTH_DEF   = 32;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_FRAC        = 24;
    localparam int N_PORTS          = 5;
    localparam int N_ROWS           = 5;
    localparam int N_COEF           = N_ROWS * N_PORTS;

    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_LAST,
        S_ROUND
    } t_state;

endpackage

// ----- design/wave_digital_filter_step.sv -----
// A coefficient write leaves the block idle, and it is ready again on the next cycle.
// A sample runs from acceptance to a valid result through 5 rows, each of 10 half-width
// multiplies, one final accumulate and one round and saturate, on one multiplier.
// A new sample waits until the last is done, and the last round waits on a stalled result.
// Synchronous active-low reset clears the coefficients, the four states and the output valid.
module wave_digital_filter_step #(
    parameter int COEF_WIDTH   = wdfs_pkg::COEF_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = wdfs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cmd,
    input  logic [4:0]                     i_coef_index,
    input  logic signed [31:0]             i_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_sample
);

    localparam int CF     = wdfs_pkg::COEF_FRAC;
    localparam int SF     = SAMPLE_WIDTH - 1;
    localparam int IW     = (COEF_WIDTH > 26) ? COEF_WIDTH : 26;
    localparam int LO_W   = IW / 2;
    localparam int B_W    = LO_W + 1;
    localparam int P_W    = COEF_WIDTH + B_W;
    localparam int ACC_W  = COEF_WIDTH + IW + 3;
    localparam int SH_OUT = 2 * CF + 1 - SF;

    localparam logic signed [ACC_W-1:0] RC_ST  = ACC_W'(1) << (CF - 1);
    localparam logic signed [ACC_W-1:0] RC_OUT = ACC_W'(1) << (SH_OUT - 1);

    wdfs_pkg::t_state r_state, n_state;

    logic signed [COEF_WIDTH-1:0] r_coef [wdfs_pkg::N_COEF];
    logic signed [COEF_WIDTH-1:0] r_wave [4];
    logic signed [COEF_WIDTH-1:0] r_next [4];
    logic signed [IW-1:0]         r_inc3;
    logic signed [P_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic [2:0]                   r_row;
    logic [2:0]                   r_col;
    logic                         r_half;
    logic [4:0]                   r_cidx;
    logic                         r_pv;
    logic                         r_ph;
    logic                         r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic in_ready, issue, rounding, out_load;
    logic accept, accept_proc, accept_write;

    logic signed [COEF_WIDTH-1:0] w_coef_in;
    logic signed [IW-1:0]         w_align;
    logic signed [IW-1:0]         w_inc;
    logic signed [B_W-1:0]        w_b;
    logic signed [P_W-1:0]        w_prod;
    logic signed [ACC_W-1:0]      w_addend;
    logic signed [ACC_W-1:0]      w_term;
    logic signed [ACC_W-1:0]      w_st_shr;
    logic signed [ACC_W-1:0]      w_out_shr;
    logic signed [COEF_WIDTH-1:0] w_st_sat;
    logic signed [SAMPLE_WIDTH-1:0] w_out_sat;
    logic                         w_st_ovf;
    logic                         w_out_ovf;

    generate
        if (COEF_WIDTH <= 32) begin : g_coef_trunc
            assign w_coef_in = i_coef_value[COEF_WIDTH-1:0];
        end else begin : g_coef_ext
            assign w_coef_in = COEF_WIDTH'(i_coef_value);
        end
    endgenerate

    generate
        if (SF <= CF) begin : g_align_shl
            assign w_align = IW'(i_in_sample) <<< (CF - SF);
        end else begin : g_align_rnd
            localparam logic signed [SAMPLE_WIDTH:0] RND_S =
                (SAMPLE_WIDTH + 1)'(1) << (SF - CF - 1);
            logic signed [SAMPLE_WIDTH:0] w_tmp;
            assign w_tmp   = (SAMPLE_WIDTH + 1)'(i_in_sample) + RND_S;
            assign w_align = IW'(w_tmp >>> (SF - CF));
        end
    endgenerate

    always_comb begin
        case (r_col)
            3'd0:    w_inc = IW'(r_wave[0]);
            3'd1:    w_inc = IW'(r_wave[1]);
            3'd2:    w_inc = IW'(r_wave[2]);
            3'd3:    w_inc = r_inc3;
            3'd4:    w_inc = IW'(r_wave[3]);
            default: w_inc = '0;
        endcase
    end

    assign w_b      = r_half ? B_W'($signed(w_inc[IW-1:LO_W]))
                             : $signed({1'b0, w_inc[LO_W-1:0]});
    assign w_prod   = P_W'(r_coef[r_cidx]) * P_W'(w_b);
    assign w_addend = ACC_W'(r_prod);
    assign w_term   = r_ph ? (w_addend <<< LO_W) : w_addend;

    assign w_st_shr  = r_acc >>> CF;
    assign w_out_shr = r_acc >>> SH_OUT;
    assign w_st_ovf  = !((&w_st_shr[ACC_W-1:COEF_WIDTH-1]) ||
                         !(|w_st_shr[ACC_W-1:COEF_WIDTH-1]));
    assign w_out_ovf = !((&w_out_shr[ACC_W-1:SAMPLE_WIDTH-1]) ||
                         !(|w_out_shr[ACC_W-1:SAMPLE_WIDTH-1]));
    assign w_st_sat  = w_st_ovf
        ? (w_st_shr[ACC_W-1] ? {1'b1, {(COEF_WIDTH-1){1'b0}}} : {1'b0, {(COEF_WIDTH-1){1'b1}}})
        : w_st_shr[COEF_WIDTH-1:0];
    assign w_out_sat = w_out_ovf
        ? (w_out_shr[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                              : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
        : w_out_shr[SAMPLE_WIDTH-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            wdfs_pkg::S_IDLE: begin
                if (i_in_valid && i_cmd == wdfs_pkg::CMD_PROCESS) begin
                    n_state = wdfs_pkg::S_MAC;
                end
            end
            wdfs_pkg::S_MAC: begin
                if (r_col == 3'(wdfs_pkg::N_PORTS - 1) && r_half) begin
                    n_state = wdfs_pkg::S_LAST;
                end
            end
            wdfs_pkg::S_LAST: begin
                n_state = wdfs_pkg::S_ROUND;
            end
            wdfs_pkg::S_ROUND: begin
                if (r_row != 3'(wdfs_pkg::N_ROWS - 1)) begin
                    n_state = wdfs_pkg::S_MAC;
                end else if (!r_out_valid || i_out_ready) begin
                    n_state = wdfs_pkg::S_IDLE;
                end
            end
            default: n_state = wdfs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        rounding = 1'b0;
        out_load = 1'b0;
        case (r_state)
            wdfs_pkg::S_IDLE:  in_ready = 1'b1;
            wdfs_pkg::S_MAC:   issue    = 1'b1;
            wdfs_pkg::S_LAST:  ;
            wdfs_pkg::S_ROUND: begin
                rounding = 1'b1;
                out_load = (r_row == 3'(wdfs_pkg::N_ROWS - 1)) &&
                           (!r_out_valid || i_out_ready);
            end
            default: ;
        endcase
    end

    assign accept       = in_ready && i_in_valid;
    assign accept_proc  = accept && i_cmd == wdfs_pkg::CMD_PROCESS;
    assign accept_write = accept && i_cmd == wdfs_pkg::CMD_WRITE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wdfs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_ph        <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_half      <= 1'b0;
            r_cidx      <= '0;
            for (int i = 0; i < wdfs_pkg::N_COEF; i++) begin
                r_coef[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_wave[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
            r_ph    <= r_half;

            if (accept_write && i_coef_index < 5'(wdfs_pkg::N_COEF)) begin
                r_coef[i_coef_index] <= w_coef_in;
            end

            if (accept_proc) begin
                r_row  <= '0;
                r_col  <= '0;
                r_half <= 1'b0;
                r_cidx <= '0;
                r_inc3 <= w_align;
                r_acc  <= RC_ST;
            end

            if (issue) begin
                r_prod <= w_prod;
                if (r_half) begin
                    r_half <= 1'b0;
                    r_col  <= r_col + 3'd1;
                    r_cidx <= r_cidx + 5'd1;
                end else begin
                    r_half <= 1'b1;
                end
            end

            if (r_pv) begin
                r_acc <= r_acc + w_term;
            end

            if (rounding && r_row != 3'(wdfs_pkg::N_ROWS - 1)) begin
                r_next[r_row[1:0]] <= w_st_sat;
                r_row  <= r_row + 3'd1;
                r_col  <= '0;
                r_half <= 1'b0;
                r_acc  <= (r_row == 3'(wdfs_pkg::N_ROWS - 2)) ? RC_OUT : RC_ST;
            end

            if (out_load) begin
                r_out       <= w_out_sat;
                r_out_valid <= 1'b1;
                for (int i = 0; i < 4; i++) begin
                    r_wave[i] <= r_next[i];
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready   = in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out;

endmodule

// ----- design/wdfs_checker.sv -----
module wdfs_checker #(
    parameter int SAMPLE_WIDTH = wdfs_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    i_cmd,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] o_out_sample
);

    // A word that is not taken keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_sample))
        else $error("output word changed or dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A sample keeps the block busy for the next cycle.
    a_proc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == wdfs_pkg::CMD_PROCESS |=> !o_in_ready)
        else $error("ready right after a sample was taken");

    // After a coefficient write the block is ready again on the next cycle.
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == wdfs_pkg::CMD_WRITE |=> o_in_ready)
        else $error("not ready after a coefficient write");

    // A new result only comes at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a preceding computation");

endmodule

bind wave_digital_filter_step wdfs_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_wdfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_sample(o_out_sample)
);
